### rtl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

    localparam int unsigned RkWords = 60;
    localparam int unsigned RkAddrW = 6;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] inv_box(input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (FWD_BOX[i] == b) r = 8'(i);
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] b);
        return xtime(xtime(xtime(b))) ^ b;
    endfunction
    function automatic logic [7:0] mul11(input logic [7:0] b);
        return xtime(xtime(xtime(b))) ^ xtime(b) ^ b;
    endfunction
    function automatic logic [7:0] mul13(input logic [7:0] b);
        return xtime(xtime(xtime(b))) ^ xtime(xtime(b)) ^ b;
    endfunction
    function automatic logic [7:0] mul14(input logic [7:0] b);
        return xtime(xtime(xtime(b))) ^ xtime(xtime(b)) ^ xtime(b);
    endfunction

    // one 32-bit column through inv mix columns, byte 0 in bits 31:24
    function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
        logic [7:0] a [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) a[i] = w[31-8*i -: 8];
        for (int i = 0; i < 4; i++) begin
            r[31-8*i -: 8] = mul14(a[i]) ^ mul11(a[(i+1)%4])
                           ^ mul13(a[(i+2)%4]) ^ mul9(a[(i+3)%4]);
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [7:0] a [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) a[i] = w[31-8*i -: 8];
        for (int i = 0; i < 4; i++) begin
            r[31-8*i -: 8] = xtime(a[i]) ^ xtime(a[(i+1)%4]) ^ a[(i+1)%4]
                           ^ a[(i+2)%4] ^ a[(i+3)%4];
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

    function automatic logic [3:0] round_count(input logic [1:0] ks);
        logic [3:0] nr;
        case (ks)
            KEY_128: nr = 4'd10;
            KEY_192: nr = 4'd12;
            default: nr = 4'd14;
        endcase
        return nr;
    endfunction

    typedef struct packed {
        logic               valid;
        logic               dec;
        logic [RkAddrW-1:0] addr;
    } t_rk_rd;

endpackage

### rtl/aes_key_sched.sv
`timescale 1ns / 1ps
// expands the round keys one word per cycle, then fills the inverse schedule
module aes_key_sched import aes_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_key_size,
    input  logic [255:0]  i_key,
    input  t_rk_rd        i_rd,
    output logic [31:0]   o_rd_word,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ENC  = 3'b010,
        S_DEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_enc [RkWords];
    logic [31:0] r_dec [RkWords];
    logic [5:0]  r_idx, n_idx;
    logic [3:0]  r_nk_pos, n_nk_pos;   // i mod nk
    logic [7:0]  r_rcon, n_rcon;
    logic [31:0] r_win [8];             // last eight words written, newest first
    logic [31:0] r_src;                 // forward word read for the inverse schedule
    logic        r_src_plain;
    logic [5:0]  r_src_idx;
    logic        r_src_vld;
    logic [31:0] r_rd_word;
    logic [5:0]  r_total;
    logic [3:0]  r_nr;
    logic [3:0]  r_nk;
    logic [255:0] r_key;

    logic [31:0] w_back;      // word i - nk
    logic [31:0] w_t;
    logic [31:0] w_new;
    logic [5:0]  w_src_addr;
    logic [5:0]  w_rnd;
    logic [1:0]  w_col;
    logic        w_plain;

    always_comb begin
        case (r_nk)
            4'd4:    w_back = r_win[3];
            4'd6:    w_back = r_win[5];
            default: w_back = r_win[7];
        endcase
    end

    always_comb begin
        w_t = r_win[0];
        if (r_nk_pos == 4'd0) begin
            w_t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_nk == 4'd8 && r_nk_pos == 4'd4) begin
            w_t = sub_word(r_win[0]);
        end
        if (r_idx < 6'(r_nk)) begin
            w_new = r_key[255 - 32*r_idx[2:0] -: 32];
        end else begin
            w_new = w_back ^ w_t;
        end
    end

    // inverse schedule: dec word 4r+c comes from enc word 4(nr-r)+c
    assign w_rnd      = {2'b00, r_idx[5:2]};
    assign w_col      = r_idx[1:0];
    assign w_src_addr = 6'({6'(r_nr) - w_rnd, 2'b00}) | {4'b0, w_col};
    assign w_plain    = (w_rnd == 6'd0) || (w_rnd == 6'(r_nr));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_nk_pos = r_nk_pos;
        n_rcon   = r_rcon;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state  = S_ENC;
                    n_idx    = 6'd0;
                    n_nk_pos = 4'd0;
                    n_rcon   = 8'h01;
                end
            end
            S_ENC: begin
                n_idx = r_idx + 6'd1;
                if (r_idx >= 6'(r_nk) && r_nk_pos == 4'd0) n_rcon = xtime(r_rcon);
                n_nk_pos = (r_nk_pos == r_nk - 4'd1) ? 4'd0 : r_nk_pos + 4'd1;
                if (r_idx == r_total - 6'd1) begin
                    n_state = S_DEC;
                    n_idx   = 6'd0;
                end
            end
            S_DEC: begin
                // one extra slot for the write behind the registered read
                n_idx = r_idx + 6'd1;
                if (r_idx == r_total) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= 6'd0;
            r_nk_pos  <= 4'd0;
            r_rcon    <= 8'h01;
            r_src_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_nk_pos  <= n_nk_pos;
            r_rcon    <= n_rcon;
            r_src_vld <= (r_state == S_DEC) && (r_idx < r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_nr    <= round_count(i_key_size);
            r_nk    <= round_count(i_key_size) - 4'd6;
            r_total <= 6'({round_count(i_key_size), 2'b00}) + 6'd4;
            r_key   <= i_key;
        end
        if (r_state == S_ENC) begin
            r_enc[r_idx] <= w_new;
            r_win[0]     <= w_new;
            for (int i = 1; i < 8; i++) r_win[i] <= r_win[i-1];
        end
        if (r_state == S_DEC && r_idx < r_total) begin
            r_src       <= r_enc[w_src_addr];
            r_src_plain <= w_plain;
            r_src_idx   <= r_idx;
        end
        if (r_src_vld) begin
            r_dec[r_src_idx] <= r_src_plain ? r_src : inv_mix_word(r_src);
        end
        if (i_rd.valid) begin
            r_rd_word <= i_rd.dec ? r_dec[i_rd.addr] : r_enc[i_rd.addr];
        end
    end

    assign o_rd_word = r_rd_word;
    assign o_busy    = (r_state != S_IDLE);

endmodule

### rtl/aes_round_core.sv
`timescale 1ns / 1ps
// serial datapath: state shifts one 32-bit column per cycle through a key add,
// a full round is a substitution pass followed by a column-serial key add pass
module aes_round_core import aes_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic          i_dec,
    input  logic [3:0]    i_nr,
    input  logic [127:0]  i_block,
    input  logic [31:0]   i_rk_word,
    output t_rk_rd        o_rd,
    output logic          o_done,
    output logic [127:0]  o_block,
    output logic          o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUB  = 4'b0010,
        S_KEY  = 4'b0100,
        S_LAST = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [127:0] r_s;
    logic [3:0]   r_round;
    logic [2:0]   r_col;     // column slot, 4 means read latency slot
    logic         r_dec;
    logic [3:0]   r_nr;
    logic [2:0]   r_sub_cnt;

    logic [31:0]  w_sub4;
    logic [127:0] w_sub_next;
    logic [127:0] w_shift;
    logic [31:0]  w_col_in;
    logic [31:0]  w_col_out;
    logic [5:0]   w_addr;

    // byte substitution over four bytes per cycle, rotating the state
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sub4[31-8*i -: 8] = r_dec ? inv_box(r_s[127-8*i -: 8]) : FWD_BOX[r_s[127-8*i -: 8]];
        end
    end

    assign w_sub_next = {r_s[95:0], w_sub4};

    // shift rows on the column-ordered state once every byte is substituted
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (r_dec)
                    w_shift[127 - 8*(4*c+r) -: 8] = w_sub_next[127 - 8*(4*((c+4-r)%4)+r) -: 8];
                else
                    w_shift[127 - 8*(4*c+r) -: 8] = w_sub_next[127 - 8*(4*((c+r)%4)+r) -: 8];
            end
        end
    end

    assign w_col_in = r_s[127:96];
    always_comb begin
        w_col_out = w_col_in;
        if (r_round != 4'd0 && r_round != r_nr) begin
            w_col_out = r_dec ? inv_mix_word(w_col_in) : mix_word(w_col_in);
        end
    end

    assign w_addr = 6'({r_round, 2'b00}) | 6'(r_col[1:0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_go) n_state = S_KEY;
            S_SUB:   if (r_sub_cnt == 3'd3) n_state = S_KEY;
            S_KEY:   if (r_col == 3'd4) n_state = (r_round == r_nr) ? S_LAST : S_SUB;
            S_LAST:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    r_s     <= i_block;
                    r_dec   <= i_dec;
                    r_nr    <= i_nr;
                    r_round <= 4'd0;
                    r_col   <= 3'd0;
                end
            end
            S_SUB: begin
                r_s       <= (r_sub_cnt == 3'd3) ? w_shift : w_sub_next;
                r_sub_cnt <= r_sub_cnt + 3'd1;
                r_col     <= 3'd0;
            end
            S_KEY: begin
                // key word for column c arrives in the slot after its read, from the registered key read
                if (r_col != 3'd0) begin
                    r_s <= {r_s[95:0], w_col_out ^ i_rk_word};
                end
                if (r_col == 3'd4) begin
                    r_round   <= r_round + 4'd1;
                    r_sub_cnt <= 3'd0;
                end else begin
                    r_col <= r_col + 3'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_rd.valid = (r_state == S_KEY) && (r_col < 3'd4);
    assign o_rd.dec   = r_dec;
    assign o_rd.addr  = w_addr;
    assign o_done     = (r_state == S_LAST);
    assign o_block    = r_s;
    assign o_busy     = (r_state != S_IDLE);

endmodule

### rtl/aes_block_cipher.sv
`timescale 1ns / 1ps
// each round is a substitution pass, four bytes at a time, then a column-serial key add that
// reads one round key word per column; o_done follows the last key add (10/12/14 rounds)
// busy drops the cycle after o_done; a new item is taken only once the previous one is done
// key expansion after a write to the key size or a key word register holds busy high
// reset: synchronous active-low; clears control and registers, round keys undefined
// the result is shown for one cycle on o_done; the receiver cannot stall
module aes_block_cipher import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         i_kind,
    input  logic [63:0]  i_block_high,
    input  logic [63:0]  i_block_low,
    output logic         o_done,
    output logic [63:0]  o_result_high,
    output logic [63:0]  o_result_low,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [1:0]   r_key_size;
    logic [63:0]  r_key_w [4];
    logic         r_kick;          // expansion request after a key register write
    logic         w_wr;
    logic [2:0]   w_reg;
    logic         w_ks_busy;
    logic         w_rc_busy;
    logic [31:0]  w_rk_word;
    t_rk_rd       w_rd;
    logic [127:0] w_out;
    logic [3:0]   w_nr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= KEY_128;
            for (int i = 0; i < 4; i++) r_key_w[i] <= 64'h0;
            r_kick     <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            if (w_wr) begin
                case (w_reg)
                    REG_KEY_SIZE: begin r_key_size <= pwdata[1:0]; r_kick <= 1'b1; end
                    REG_KEY_W0:   begin r_key_w[0] <= pwdata; r_kick <= 1'b1; end
                    REG_KEY_W1:   begin r_key_w[1] <= pwdata; r_kick <= 1'b1; end
                    REG_KEY_W2:   begin r_key_w[2] <= pwdata; r_kick <= 1'b1; end
                    REG_KEY_W3:   begin r_key_w[3] <= pwdata; r_kick <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    // register readback
    always_comb begin
        case (w_reg)
            REG_KEY_SIZE: prdata = {62'h0, r_key_size};
            REG_KEY_W0:   prdata = r_key_w[0];
            REG_KEY_W1:   prdata = r_key_w[1];
            REG_KEY_W2:   prdata = r_key_w[2];
            REG_KEY_W3:   prdata = r_key_w[3];
            default:      prdata = 64'h0;
        endcase
    end

    assign w_nr = round_count(r_key_size);

    aes_key_sched u_ks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kick),
        .i_key_size (r_key_size),
        .i_key      ({r_key_w[0], r_key_w[1], r_key_w[2], r_key_w[3]}),
        .i_rd       (w_rd),
        .o_rd_word  (w_rk_word),
        .o_busy     (w_ks_busy)
    );

    aes_round_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (start && !busy),
        .i_dec     (i_kind),
        .i_nr      (w_nr),
        .i_block   ({i_block_high, i_block_low}),
        .i_rk_word (w_rk_word),
        .o_rd      (w_rd),
        .o_done    (o_done),
        .o_block   (w_out),
        .o_busy    (w_rc_busy)
    );

    assign busy          = w_rc_busy || w_ks_busy || r_kick;
    assign o_result_high = w_out[127:64];
    assign o_result_low  = w_out[63:0];

    // a result only follows an accepted item
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("done without item");
    // no key read while the schedule is rebuilt
    a_no_rd_in_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd.valid |-> !w_ks_busy) else $error("key read during expansion");
    // a pending expansion request always shows as busy
    a_kick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick |-> busy) else $error("kick not busy");

endmodule

### test/tb_aes_block_cipher.sv
`timescale 1ns / 1ps
module tb_aes_block_cipher;
    import aes_pkg::*;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 150;  // above the 14-round latency

    typedef struct {
        logic        kind;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } cipher_item_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    logic         i_kind;
    logic [63:0]  i_block_high;
    logic [63:0]  i_block_low;
    logic         o_done;
    logic [63:0]  o_result_high;
    logic [63:0]  o_result_low;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    aes_block_cipher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_block_high  (i_block_high),
        .i_block_low   (i_block_low),
        .o_done        (o_done),
        .o_result_high (o_result_high),
        .o_result_low  (o_result_low),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state: mirrored registers and both key schedules
    logic [1:0]   key_size_q;
    logic [63:0]  key_word_q [4];
    logic [31:0]  enc_sched [60];
    logic [31:0]  dec_sched [60];
    logic [7:0]   inv_sbox [256];

    cipher_item_t pending_items [$];
    logic [127:0] expected_blocks [$];
    int unsigned  err_count;
    int unsigned  gap_left;
    int unsigned  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // --- gf(2^8) helpers ---------------------------------------------------
    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    // one column; byte 0 in bits 31:24; coefficients picked by direction
    function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inverse);
        logic [7:0] a [4];
        logic [7:0] c [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) a[i] = w[31-8*i -: 8];
        if (inverse) c = '{8'd14, 8'd11, 8'd13, 8'd9};
        else         c = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int i = 0; i < 4; i++) begin
            r[31-8*i -: 8] = gf_mul(a[i], c[0]) ^ gf_mul(a[(i+1)%4], c[1])
                           ^ gf_mul(a[(i+2)%4], c[2]) ^ gf_mul(a[(i+3)%4], c[3]);
        end
        return r;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

    function automatic int unsigned rounds_for(input logic [1:0] ks);
        return (ks == KEY_128) ? 10 : (ks == KEY_192) ? 12 : 14;
    endfunction

    // rebuild both schedules from the mirrored key and size
    task automatic expand_schedule();
        int unsigned nr, nk, total;
        logic [31:0] t;
        logic [7:0]  rcon;
        nr = rounds_for(key_size_q);
        nk = nr - 6;
        total = 4 * (nr + 1);
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
            enc_sched[i] = (i % 2) ? key_word_q[i/2][31:0] : key_word_q[i/2][63:32];
        for (int i = nk; i < total; i++) begin
            t = enc_sched[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end else if (nk == 8 && i % nk == 4) begin
                t = sbox_word(t);
            end
            enc_sched[i] = enc_sched[i-nk] ^ t;
        end
        // equivalent inverse cipher: reversed, inner round keys through inv mix
        for (int r = 0; r <= nr; r++)
            for (int i = 0; i < 4; i++)
                dec_sched[4*r+i] = (r == 0 || r == nr) ? enc_sched[4*(nr-r)+i]
                                 : mix_col(enc_sched[4*(nr-r)+i], 1'b1);
    endtask

    function automatic logic [127:0] round_key(input logic dec, input int unsigned r);
        return dec ? {dec_sched[4*r], dec_sched[4*r+1], dec_sched[4*r+2], dec_sched[4*r+3]}
                   : {enc_sched[4*r], enc_sched[4*r+1], enc_sched[4*r+2], enc_sched[4*r+3]};
    endfunction

    // whole block through the cipher, byte i of the state in bits 127-8i
    function automatic logic [127:0] cipher_block(input cipher_item_t it);
        logic [127:0] s, t;
        int unsigned nr, src;
        nr = rounds_for(key_size_q);
        s = {it.block_high, it.block_low} ^ round_key(it.kind, 0);
        for (int r = 1; r <= nr; r++) begin
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++) begin
                    if (it.kind) begin
                        src = 4 * ((c + 4 - b) % 4) + b;
                        t[127-8*(4*c+b) -: 8] = inv_sbox[s[127-8*src -: 8]];
                    end else begin
                        src = 4 * ((c + b) % 4) + b;
                        t[127-8*(4*c+b) -: 8] = FWD_BOX[s[127-8*src -: 8]];
                    end
                end
            if (r < nr)
                for (int c = 0; c < 4; c++)
                    t[127-32*c -: 32] = mix_col(t[127-32*c -: 32], it.kind);
            s = t ^ round_key(it.kind, r);
        end
        return s;
    endfunction

    // --- driver: one item per start/busy handshake, random gaps -------------
    always @(posedge i_clk) begin
        cipher_item_t it;
        int unsigned  pick;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_kind       <= 1'b0;
            i_block_high <= '0;
            i_block_low  <= '0;
            gap_left = 0;
        end else begin
            if (start && !busy)
                expected_blocks.push_back(cipher_block('{i_kind, i_block_high, i_block_low}));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    // gap cycles count only once the block is ready again
                    if (!busy) gap_left--;
                    start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    i_kind       <= it.kind;
                    i_block_high <= it.block_high;
                    i_block_low  <= it.block_low;
                    start        <= 1'b1;
                    // mostly back to back or short gaps, now and then a long one
                    pick = $urandom_range(0, 99);
                    gap_left = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                             : $urandom_range(10, 40);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // --- monitor: each strobe checked against the oldest expectation --------
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && o_done) begin
            if (expected_blocks.size() == 0) begin
                $error("result_high/result_low: no item outstanding, got %h %h",
                       o_result_high, o_result_low);
                err_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (o_result_high !== want[127:64]) begin
                    $error("result_high: expected %h, actual %h", want[127:64], o_result_high);
                    err_count++;
                end
                if (o_result_low !== want[63:0]) begin
                    $error("result_low: expected %h, actual %h", want[63:0], o_result_low);
                    err_count++;
                end
            end
        end
    end

    // --- watchdog: cycles with no handshake of any kind ---------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // wait until every item went out and came back, then let the core settle
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || start || expected_blocks.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup then access; mirror it into the predictor
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_KEY_SIZE) begin
            key_size_q = data[1:0];
            expand_schedule();
        end else if (idx <= REG_KEY_W3) begin
            key_word_q[idx-1] = data;
            expand_schedule();
        end
        // key expansion holds busy; wait for it to clear
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        reg_write(REG_KEY_SIZE, {62'h0, ks});
        reg_write(REG_KEY_W0, k0);
        reg_write(REG_KEY_W1, k1);
        reg_write(REG_KEY_W2, k2);
        reg_write(REG_KEY_W3, k3);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_item(input logic kind, input logic [63:0] hi, input logic [63:0] lo);
        pending_items.push_back('{kind, hi, lo});
    endtask

    localparam logic [63:0] PT_HI = 64'h0011223344556677;
    localparam logic [63:0] PT_LO = 64'h8899aabbccddeeff;
    localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;

    initial begin
        logic [1:0]  ks;
        logic [63:0] kw [4];
        int unsigned sel;

        for (int i = 0; i < 256; i++) inv_sbox[FWD_BOX[i]] = 8'(i);
        err_count = 0;
        key_size_q = KEY_128;
        for (int i = 0; i < 4; i++) key_word_q[i] = '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // standard 128-bit vector, both directions, plus all-zero and all-one blocks
        load_key(KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        queue_item(1'b0, PT_HI, PT_LO);
        queue_item(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        queue_item(1'b0, '0, '0);
        queue_item(1'b1, '0, '0);
        queue_item(1'b0, ONES, ONES);
        queue_item(1'b1, ONES, ONES);
        drain();

        // 192-bit key; words past the key length hold ones and must not matter
        reg_write(REG_KEY_W3, ONES);
        reg_write(REG_KEY_SIZE, {62'h0, KEY_192});
        queue_item(1'b0, PT_HI, PT_LO);
        queue_item(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        queue_item(1'b0, ONES, '0);
        queue_item(1'b1, '0, ONES);
        drain();

        // 256-bit key
        reg_write(REG_KEY_W3, 64'h18191a1b1c1d1e1f);
        reg_write(REG_KEY_SIZE, {62'h0, KEY_256});
        queue_item(1'b0, PT_HI, PT_LO);
        queue_item(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        queue_item(1'b0, 64'h8000000000000000, 64'h1);
        drain();

        // unused size code behaves as 256-bit; upper data bits ignored
        reg_write(REG_KEY_SIZE, ONES);
        queue_item(1'b0, PT_HI, PT_LO);
        queue_item(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();

        // writes beyond the last register change nothing
        reg_write(3'd5, rand64());
        reg_write(3'd7, ONES);
        queue_item(1'b0, PT_HI, PT_LO);
        queue_item(1'b1, rand64(), rand64());
        drain();

        // random phases: new key and size each time, extremes in the first ones
        for (int ph = 0; ph < 11; ph++) begin
            ks = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
            for (int i = 0; i < 4; i++)
                kw[i] = (ph == 1) ? '0 : (ph == 2) ? ONES : rand64();
            load_key(ks, kw[0], kw[1], kw[2], kw[3]);
            for (int n = 0; n < 100; n++) begin
                sel = $urandom_range(0, 19);
                queue_item(1'($urandom),
                           (sel == 0) ? '0 : (sel == 1) ? ONES : rand64(),
                           (sel == 2) ? '0 : (sel == 3) ? ONES : rand64());
            end
            drain();
        end

        if (expected_blocks.size() != 0) begin
            $error("result_high/result_low: %0d items never returned", expected_blocks.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### aes_block_cipher.f
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_round_core.sv
rtl/aes_block_cipher.sv
test/tb_aes_block_cipher.sv
